// ===== src/sfr_pkg.sv =====
package sfr_pkg;

   localparam logic [7:0]  MAGIC_BYTE       = 8'hFA;
   localparam logic [7:0]  VERSION_BYTE     = 8'h03;
   localparam logic [7:0]  ADDRESS_BYTE     = 8'h00;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd1014;

   typedef enum logic [2:0] {
      PH_MAGIC   = 3'd0,
      PH_VERSION = 3'd1,
      PH_ADDR    = 3'd2,
      PH_CMD     = 3'd3,
      PH_SEQ     = 3'd4,
      PH_LEN     = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_CSUM    = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_DATA    = 3'd1,
      EV_DONE    = 3'd2,
      EV_SYNC    = 3'd3,
      EV_VERSION = 3'd4,
      EV_ADDRESS = 3'd5,
      EV_LENGTH  = 3'd6
   } event_type;

   // Deframer state carried from word to word
   typedef struct packed {
      phase_type   phase;
      logic        second;      // second byte of a two-byte field
      logic [7:0]  command;
      logic [7:0]  seq_num;
      logic [15:0] length;
      logic [15:0] pay_count;
      logic [7:0]  csum_low;
   } frame_state_type;

   typedef struct packed {
      event_type   evt;
      logic [7:0]  data;
      logic [15:0] index;
      logic [7:0]  command;
      logic [7:0]  seq_num;
      logic [15:0] length;
      logic [15:0] csum;
   } frame_result_type;

endpackage

// ===== src/sfr_deframer.sv =====
module sfr_deframer (
   input  sfr_pkg::frame_state_type  cur_state,
   input  logic [7:0]                rx_byte,
   input  logic [15:0]               max_length,
   output sfr_pkg::frame_state_type  nxt_state,
   output sfr_pkg::frame_result_type result
);
   import sfr_pkg::*;

   logic [15:0] len_full;
   logic [15:0] count_inc;

   assign len_full  = {rx_byte, cur_state.length[7:0]};
   assign count_inc = cur_state.pay_count + 16'd1;

   always_comb begin
      nxt_state    = cur_state;
      result.evt   = EV_NONE;
      result.index = 16'd0;
      result.csum  = 16'd0;

      case (cur_state.phase)
         PH_VERSION: begin
            if (rx_byte == VERSION_BYTE) begin
               nxt_state.phase  = PH_ADDR;
               nxt_state.second = 1'b0;
            end else begin
               result.evt          = EV_VERSION;
               nxt_state.phase     = PH_MAGIC;
               nxt_state.second    = 1'b0;
               nxt_state.pay_count = 16'd0;
            end
         end
         PH_ADDR: begin
            if (rx_byte == ADDRESS_BYTE) begin
               if (!cur_state.second) begin
                  nxt_state.second = 1'b1;
               end else begin
                  nxt_state.second = 1'b0;
                  nxt_state.phase  = PH_CMD;
               end
            end else begin
               result.evt          = EV_ADDRESS;
               nxt_state.phase     = PH_MAGIC;
               nxt_state.second    = 1'b0;
               nxt_state.pay_count = 16'd0;
            end
         end
         PH_CMD: begin
            nxt_state.command = rx_byte;
            nxt_state.phase   = PH_SEQ;
         end
         PH_SEQ: begin
            nxt_state.seq_num = rx_byte;
            nxt_state.phase   = PH_LEN;
            nxt_state.second  = 1'b0;
         end
         PH_LEN: begin
            if (!cur_state.second) begin
               nxt_state.length = {8'd0, rx_byte};
               nxt_state.second = 1'b1;
            end else begin
               nxt_state.length    = len_full;
               nxt_state.second    = 1'b0;
               nxt_state.pay_count = 16'd0;
               if (len_full > max_length) begin
                  result.evt      = EV_LENGTH;
                  nxt_state.phase = PH_MAGIC;
               end else if (len_full == 16'd0) begin
                  nxt_state.phase = PH_CSUM;
               end else begin
                  nxt_state.phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            result.evt          = EV_DATA;
            result.index        = cur_state.pay_count;
            nxt_state.pay_count = count_inc;
            if (count_inc >= cur_state.length) begin
               nxt_state.phase  = PH_CSUM;
               nxt_state.second = 1'b0;
            end
         end
         PH_CSUM: begin
            if (!cur_state.second) begin
               nxt_state.csum_low = rx_byte;
               nxt_state.second   = 1'b1;
            end else begin
               result.evt          = EV_DONE;
               result.csum         = {rx_byte, cur_state.csum_low};
               nxt_state.phase     = PH_MAGIC;
               nxt_state.second    = 1'b0;
               nxt_state.pay_count = 16'd0;
            end
         end
         default: begin
            // hunting for the magic byte
            if (rx_byte == MAGIC_BYTE) begin
               nxt_state.phase  = PH_VERSION;
               nxt_state.second = 1'b0;
            end else begin
               result.evt          = EV_SYNC;
               nxt_state.phase     = PH_MAGIC;
               nxt_state.second    = 1'b0;
               nxt_state.pay_count = 16'd0;
            end
         end
      endcase

      result.data    = rx_byte;
      result.command = nxt_state.command;
      result.seq_num = nxt_state.seq_num;
      result.length  = nxt_state.length;
   end

endmodule

// ===== src/serial_frame_receiver_core.sv =====
// Each accepted byte's result word is registered in the result or skid register.
// One byte per cycle while not stalled; the state update is one byte-wide step.
// A two-deep output (result register plus skid register) keeps req_ open while
// one finished result waits; req_stall rises only when both are occupied.
// Reset (synchronous, active high) returns to magic-byte hunt, clears the held
// header fields and counters, empties the output and sets the limit to 1014.
module serial_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_payload_index,
   output logic [7:0]  rsp_command_code,
   output logic [7:0]  rsp_sequence_number,
   output logic [15:0] rsp_payload_length,
   output logic [15:0] rsp_frame_checksum,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import sfr_pkg::*;

   // configuration: payload length limit
   logic [15:0]      max_len_ff;

   // deframer state
   frame_state_type  state_ff;
   frame_state_type  state_in;
   frame_result_type result_in;

   // output register and skid register
   frame_result_type main_ff;
   logic             main_valid_ff;
   frame_result_type skid_ff;
   logic             skid_valid_ff;

   logic             in_fire;
   logic             out_fire;

   assign req_stall = skid_valid_ff;
   assign in_fire   = req_valid && !skid_valid_ff;
   assign out_fire  = main_valid_ff && !rsp_stall;

   sfr_deframer u_deframer (
      .cur_state  (state_ff),
      .rx_byte    (req_rx_byte),
      .max_length (max_len_ff),
      .nxt_state  (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LENGTH_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_MAGIC;
         state_ff.second    <= 1'b0;
         state_ff.command   <= 8'd0;
         state_ff.seq_num   <= 8'd0;
         state_ff.length    <= 16'd0;
         state_ff.pay_count <= 16'd0;
         state_ff.csum_low  <= 8'd0;
      end else if (in_fire) begin
         state_ff <= state_in;
      end
   end

   // Skid handling: a new word goes to the result register when it is free or
   // draining this cycle, otherwise it parks in the skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_fire) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            main_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_fire) begin
            main_ff <= skid_ff;
         end
      end else if (in_fire) begin
         if (!main_valid_ff || out_fire) begin
            main_ff <= result_in;
         end else begin
            skid_ff <= result_in;
         end
      end
   end

   assign rsp_valid           = main_valid_ff;
   assign rsp_event_res       = main_ff.evt;
   assign rsp_data_byte       = main_ff.data;
   assign rsp_payload_index   = main_ff.index;
   assign rsp_command_code    = main_ff.command;
   assign rsp_sequence_number = main_ff.seq_num;
   assign rsp_payload_length  = main_ff.length;
   assign rsp_frame_checksum  = main_ff.csum;

endmodule

// ===== src/sfr_checker.sv =====
module sfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_event_res,
   input logic [7:0]  rsp_data_byte,
   input logic [15:0] rsp_payload_index,
   input logic [15:0] rsp_payload_length,
   input logic [15:0] rsp_frame_checksum
);
   import sfr_pkg::*;

   // output empties on reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_event_res) && $stable(rsp_data_byte))
      else $error("stalled result word changed");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_DATA |-> rsp_payload_index < rsp_payload_length)
      else $error("payload index beyond frame length");

   a_index_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_DATA |-> rsp_payload_index == 16'd0)
      else $error("payload index set outside payload word");

   a_csum_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_DONE |-> rsp_frame_checksum == 16'd0)
      else $error("checksum set outside frame done");

endmodule

bind serial_frame_receiver_core sfr_checker u_sfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_event_res      (rsp_event_res),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_payload_index  (rsp_payload_index),
   .rsp_payload_length (rsp_payload_length),
   .rsp_frame_checksum (rsp_frame_checksum)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import sfr_pkg::*;

   // Run-length guard: roughly 1300 words, slowest when both sides idle heavily, plus
   // the long output hold-off. This limit is many times what such a run needs.
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_OFF_CYCLES = 300;

   // One result word, as the predictor and the checker see it
   typedef struct packed {
      event_type   evt;
      logic [7:0]  data;
      logic [15:0] index;
      logic [7:0]  cmd;
      logic [7:0]  seq_no;
      logic [15:0] len;
      logic [15:0] csum;
   } frame_word_type;

   // Directed stimulus row; want is only used where typed is set
   typedef struct {
      logic [7:0]     rx;
      bit             typed;
      frame_word_type want;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_event_res;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_payload_index;
   logic [7:0]  rsp_command_code;
   logic [7:0]  rsp_sequence_number;
   logic [15:0] rsp_payload_length;
   logic [15:0] rsp_frame_checksum;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   serial_frame_receiver_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_event_res       (rsp_event_res),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_command_code    (rsp_command_code),
      .rsp_sequence_number (rsp_sequence_number),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_frame_checksum  (rsp_frame_checksum),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // Deframer prediction state (mirrors the block's own)
   phase_type   rx_phase;
   bit          rx_second;     // second byte of address, length or checksum
   logic [7:0]  held_cmd;
   logic [7:0]  held_seq;
   logic [15:0] held_len;
   logic [15:0] pay_count;
   logic [7:0]  csum_low;
   logic [15:0] length_limit;

   frame_word_type   pending_words[$];   // expected words, oldest first
   directed_row_type directed_rows[$];

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_len = 0;
   int          hold_seq = 0;        // bumped to ask the stall process for a hold-off
   int          sent_bytes = 0;
   int          words_seen = 0;
   int          word_errors = 0;
   int          evt_tally[8];
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor: one received byte in, the word it should produce out.
   // Error paths drop back to the magic-byte hunt; header fields are kept.
   // ---------------------------------------------------------------------------
   function automatic frame_word_type deframe_byte(input logic [7:0] b);
      frame_word_type w;
      bit             restart;
      w       = '0;
      w.evt   = EV_NONE;
      w.data  = b;
      restart = 1'b0;
      case (rx_phase)
         PH_VERSION: begin
            if (b == VERSION_BYTE) begin
               rx_phase  = PH_ADDR;
               rx_second = 1'b0;
            end else begin
               w.evt   = EV_VERSION;
               restart = 1'b1;
            end
         end
         PH_ADDR: begin
            // both address bytes must be zero
            if (b != ADDRESS_BYTE) begin
               w.evt   = EV_ADDRESS;
               restart = 1'b1;
            end else if (!rx_second) begin
               rx_second = 1'b1;
            end else begin
               rx_second = 1'b0;
               rx_phase  = PH_CMD;
            end
         end
         PH_CMD: begin
            held_cmd = b;
            rx_phase = PH_SEQ;
         end
         PH_SEQ: begin
            held_seq  = b;
            rx_phase  = PH_LEN;
            rx_second = 1'b0;
         end
         PH_LEN: begin
            if (!rx_second) begin
               // low byte alone is visible until the high byte lands
               held_len  = {8'h00, b};
               rx_second = 1'b1;
            end else begin
               held_len  = {b, held_len[7:0]};
               rx_second = 1'b0;
               pay_count = '0;
               if (held_len > length_limit) begin
                  w.evt   = EV_LENGTH;
                  restart = 1'b1;
               end else if (held_len == 16'h0000) begin
                  rx_phase = PH_CSUM;   // empty payload: checksum follows directly
               end else begin
                  rx_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            w.evt     = EV_DATA;
            w.index   = pay_count;
            pay_count = pay_count + 16'd1;
            if (pay_count >= held_len) begin
               rx_phase  = PH_CSUM;
               rx_second = 1'b0;
            end
         end
         PH_CSUM: begin
            if (!rx_second) begin
               csum_low  = b;
               rx_second = 1'b1;
            end else begin
               w.evt   = EV_DONE;
               w.csum  = {b, csum_low};
               restart = 1'b1;
            end
         end
         default: begin
            // hunting for the magic byte
            if (b == MAGIC_BYTE) begin
               rx_phase  = PH_VERSION;
               rx_second = 1'b0;
            end else begin
               w.evt   = EV_SYNC;
               restart = 1'b1;
            end
         end
      endcase
      if (restart) begin
         rx_phase  = PH_MAGIC;
         rx_second = 1'b0;
         pay_count = '0;
      end
      w.cmd    = held_cmd;
      w.seq_no = held_seq;
      w.len    = held_len;
      return w;
   endfunction

   function automatic void add_row(input logic [7:0] rx, input bit typed = 1'b0,
                                   input event_type evt = EV_NONE,
                                   input logic [7:0] cmd = 8'h00,
                                   input logic [7:0] seq_no = 8'h00,
                                   input logic [15:0] len = 16'h0000,
                                   input logic [15:0] csum = 16'h0000);
      directed_row_type row;
      row.rx          = rx;
      row.typed       = typed;
      row.want        = '0;
      row.want.evt    = evt;
      row.want.data   = rx;
      row.want.cmd    = cmd;
      row.want.seq_no = seq_no;
      row.want.len    = len;
      row.want.csum   = csum;
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: called at a falling edge, returns at a falling edge after the word
   // has been taken. Valid is left high so back-to-back words need no gap.
   // ---------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b, input bit typed,
                            input frame_word_type typed_word);
      frame_word_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // taken at this edge: the predictor always advances, typed rows override
      predicted = deframe_byte(b);
      pending_words.push_back(typed ? typed_word : predicted);
      sent_bytes++;
      @(negedge clock);
   endtask

   // Sender stops and waits for every expected word, then lets the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      length_limit = value;
   endtask

   // Mostly well-formed frames with random content; the rest broken frames and
   // line noise. Lengths stay small so frames complete often.
   task automatic random_traffic(input int n_bytes);
      logic [7:0] frame_bytes[$];
      logic [7:0] header[8];
      int         start;
      int         kind;
      int         pick;
      int         len;
      int         cap;
      int         pos;
      int         cut;
      start = sent_bytes;
      while (sent_bytes - start < n_bytes) begin
         frame_bytes.delete();
         kind = $urandom_range(99);
         if (kind < 12) begin
            repeat ($urandom_range(6, 1)) frame_bytes.push_back(8'($urandom_range(255)));
         end else begin
            cap  = (length_limit < 16'd12) ? int'(length_limit) : 12;
            pick = $urandom_range(99);
            if (pick < 8 && length_limit != 16'hFFFF)
               len = $urandom_range(65535, int'(length_limit) + 1);   // over the limit
            else if (pick < 14)
               len = $urandom_range((length_limit < 16'd300) ? int'(length_limit) : 300);
            else
               len = $urandom_range(cap);
            header = '{MAGIC_BYTE, VERSION_BYTE, ADDRESS_BYTE, ADDRESS_BYTE,
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       len[7:0], len[15:8]};
            foreach (header[i]) frame_bytes.push_back(header[i]);
            if (len <= int'(length_limit)) begin
               repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
               repeat (2) frame_bytes.push_back(8'($urandom_range(255)));
            end
            if (kind >= 82) begin
               if ($urandom_range(1) == 0) begin
                  // flip bits in magic, version or an address byte
                  pos = $urandom_range(3);
                  frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(255, 1));
               end else begin
                  // cut short; what follows is read as the rest of this frame
                  cut = $urandom_range(frame_bytes.size() - 1, 1);
                  while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
               end
            end
         end
         foreach (frame_bytes[i]) push_byte(frame_bytes[i], 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Receiver stall: random per cycle, or a long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      int seen_hold;
      seen_hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != seen_hold) begin
            seen_hold = hold_seq;
            repeat (hold_len) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Result checker: every word taken is matched against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : word_check
      frame_word_type seen;
      frame_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.evt    = event_type'(rsp_event_res);
         seen.data   = rsp_data_byte;
         seen.index  = rsp_payload_index;
         seen.cmd    = rsp_command_code;
         seen.seq_no = rsp_sequence_number;
         seen.len    = rsp_payload_length;
         seen.csum   = rsp_frame_checksum;
         words_seen++;
         evt_tally[rsp_event_res]++;
         if (pending_words.size() == 0) begin
            word_errors++;
            if (word_errors <= 10)
               $display("Unexpected word at cycle %0d: ev=%0d data=%h",
                        cycle_count, rsp_event_res, rsp_data_byte);
         end else begin
            want = pending_words.pop_front();
            if (seen.evt !== want.evt || seen.data !== want.data ||
                seen.index !== want.index || seen.cmd !== want.cmd ||
                seen.seq_no !== want.seq_no || seen.len !== want.len ||
                seen.csum !== want.csum) begin
               word_errors++;
               if (word_errors <= 10) begin
                  $display("Mismatch at cycle %0d:", cycle_count);
                  $display("  expected ev=%0d data=%h idx=%0d cmd=%h seq=%h len=%0d csum=%h",
                           want.evt, want.data, want.index, want.cmd,
                           want.seq_no, want.len, want.csum);
                  $display("  actual   ev=%0d data=%h idx=%0d cmd=%h seq=%h len=%0d csum=%h",
                           rsp_event_res, seen.data, seen.index, seen.cmd,
                           seen.seq_no, seen.len, seen.csum);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d words outstanding",
                  cycle_count, pending_words.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      csr_wr_en   = 1'b0;
      csr_wr_data = 16'h0000;
      reset       = 1'b1;
      foreach (evt_tally[i]) evt_tally[i] = 0;

      // predictor starts from the post-reset state
      rx_phase     = PH_MAGIC;
      rx_second    = 1'b0;
      held_cmd     = 8'h00;
      held_seq     = 8'h00;
      held_len     = 16'h0000;
      pay_count    = 16'h0000;
      csum_low     = 8'h00;
      length_limit = MAX_LENGTH_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: hunt errors, bad version, bad address, an empty frame with
      // extreme header values, and a length over the reset limit
      add_row(8'h00, 1'b1, EV_SYNC);
      add_row(MAGIC_BYTE);
      add_row(8'hFF, 1'b1, EV_VERSION);
      add_row(MAGIC_BYTE);
      add_row(VERSION_BYTE);
      add_row(8'h01, 1'b1, EV_ADDRESS);
      add_row(MAGIC_BYTE);
      add_row(VERSION_BYTE);
      add_row(ADDRESS_BYTE);
      add_row(ADDRESS_BYTE);
      add_row(8'hFF);
      add_row(8'h80);
      add_row(8'h00);
      add_row(8'h00);
      add_row(8'h34);
      add_row(8'h12, 1'b1, EV_DONE, 8'hFF, 8'h80, 16'h0000, 16'h1234);
      add_row(MAGIC_BYTE);
      add_row(VERSION_BYTE);
      add_row(ADDRESS_BYTE);
      add_row(ADDRESS_BYTE);
      add_row(8'h5A);
      add_row(8'hA5);
      add_row(8'hFF);
      add_row(8'hFF, 1'b1, EV_LENGTH, 8'h5A, 8'hA5, 16'hFFFF, 16'h0000);
      foreach (directed_rows[i])
         push_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
      wait_idle();

      // reset limit, no idling on either side
      random_traffic(250);
      wait_idle();

      // limit zero: only empty frames get through; sender mostly idle
      write_limit(16'h0000);
      send_idle_pct = 86;
      random_traffic(150);
      wait_idle();

      // no limit; receiver mostly stalling
      write_limit(16'hFFFF);
      send_idle_pct = 0;
      stall_pct     = 86;
      random_traffic(250);
      wait_idle();

      // tight limit, both sides idling a third of the time
      write_limit(16'd9);
      send_idle_pct = 33;
      stall_pct     = 33;
      random_traffic(250);
      wait_idle();

      // back to the reset value; long output hold-off while bytes keep coming,
      // so the output fills and req_stall has to rise
      write_limit(MAX_LENGTH_RESET);
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_len      = HOLD_OFF_CYCLES;
      hold_seq      = hold_seq + 1;
      random_traffic(40);
      wait_idle();   // sender pauses until every word is back

      send_idle_pct = 33;
      stall_pct     = 33;
      random_traffic(260);
      wait_idle();

      $display("Sent %0d bytes and took %0d words over four length limits and four idle mixes.",
               sent_bytes, words_seen);
      $display("Words: %0d payload, %0d frames done, %0d out of sync,",
               evt_tally[EV_DATA], evt_tally[EV_DONE], evt_tally[EV_SYNC]);
      $display("       %0d bad version, %0d bad address, %0d over limit.",
               evt_tally[EV_VERSION], evt_tally[EV_ADDRESS], evt_tally[EV_LENGTH]);
      if (pending_words.size() != 0)
         $display("%0d expected words never arrived", pending_words.size());
      if (word_errors == 0 && pending_words.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
